/* rtl/core/itoa_pkg.sv */
package itoa_pkg;

  // Enough digit positions for a 64-bit operand in octal, the longest case.
  localparam int NumDigits = 22;
  localparam int DigitIdxW = $clog2(NumDigits);

  typedef logic [3:0] digit_t;
  typedef logic [NumDigits-1:0][3:0] digit_vec_t;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } base_e;

  // Control for the digit row.
  typedef struct packed {
    logic  clear;
    logic  step;
    logic  bit_in;
    base_e base;
  } row_ctrl_t;

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharHexBias = 8'h57;  // 'a' minus ten

  function automatic logic [4:0] base_value(base_e b);
    logic [4:0] r;
    case (b)
      BASE_8:  r = 5'd8;
      BASE_10: r = 5'd10;
      BASE_16: r = 5'd16;
      default: r = 5'd16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] digit_char(digit_t d);
    return {4'b0000, d} + ((d < 4'd10) ? CharZero : CharHexBias);
  endfunction

endpackage

/* rtl/core/itoa_digit_row.sv */
// Row of radix digit cells. Each step doubles the stored number in the
// selected radix and adds the incoming operand bit, so shifting the operand
// in MSB first leaves its digits in the row.
module itoa_digit_row (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itoa_pkg::row_ctrl_t   ctrl_i,
  output itoa_pkg::digit_vec_t  digits_o
);
  import itoa_pkg::*;

  digit_vec_t             digits_q, digits_d;
  logic [NumDigits-1:0]   cout;
  logic [NumDigits-1:0]   cin;
  logic [4:0]             base_val;
  logic [4:0]             dbl;

  always_comb begin
    base_val = base_value(ctrl_i.base);
    digits_d = digits_q;
    dbl      = '0;
    // The carry out depends only on the stored digit, so no ripple forms.
    for (int k = 0; k < NumDigits; k++) begin
      cout[k] = (digits_q[k] >= base_val[4:1]);
    end
    cin = {cout[NumDigits-2:0], ctrl_i.bit_in};
    for (int k = 0; k < NumDigits; k++) begin
      dbl = {digits_q[k], cin[k]};
      if (ctrl_i.clear) begin
        digits_d[k] = '0;
      end else if (ctrl_i.step) begin
        digits_d[k] = cout[k] ? 4'(dbl - base_val) : dbl[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
    end else begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

/* rtl/core/integer_to_ascii_formatter_core.sv */
// Integer to ASCII formatter. Each input transaction carries one integer
// conversion (signed decimal, unsigned decimal, octal, lower-case hex or
// pointer) and produces a stream of output transactions, one ASCII character
// each, with last set on the final character. A negative signed-decimal value
// is preceded by '-', which is not counted in the field width; pointer mode
// prints "0x" and POINTER_DIGITS zero-padded hex digits. Unused conversion
// codes produce no output. Timing: the operand is shifted MSB first through
// a shared row of radix digit cells, one bit per cycle, over all 64 bits of
// a 64-bit operand or the low 32 bits of a 32-bit one. A leading-zero scan
// then walks down from the top digit, one digit per cycle. The characters
// follow at one per cycle while the output is not stalled. The block takes
// no new item until the last one is done: in_stall_o stays high from
// acceptance until the final character has been loaded into the output
// register.
module integer_to_ascii_formatter_core #(
  parameter int MAX_WIDTH      = 63,
  parameter int POINTER_DIGITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [63:0] value_i,
  input  logic        wide_i,
  input  logic [5:0]  field_width_i,
  input  logic [1:0]  pad_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);
  import itoa_pkg::*;

  // Conversion codes.
  localparam logic [2:0] FuncSDec = 3'd0;
  localparam logic [2:0] FuncUDec = 3'd1;
  localparam logic [2:0] FuncOct  = 3'd2;
  localparam logic [2:0] FuncPtr  = 3'd4;

  // Pad codes; the unused code pads with space.
  localparam logic [1:0] PadZero = 2'd1;
  localparam logic [1:0] PadDash = 2'd2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharX     = 8'h78;

  localparam logic [5:0] MaxWidthC  = 6'(MAX_WIDTH);
  localparam logic [5:0] PtrDigitsC = 6'(POINTER_DIGITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PRE,
    ST_BODY
  } state_e;

  state_e                 state_q;
  logic [63:0]            shift_q;
  logic [5:0]             cnt_q;
  logic [DigitIdxW-1:0]   idx_q;
  logic [5:0]             pos_q;
  logic [5:0]             width_q;
  logic [7:0]             padc_q;
  logic                   ptr_q;
  logic [1:0]             pre_left_q;
  base_e                  base_q;
  logic                   out_valid_q;
  logic [7:0]             out_char_q;
  logic                   last_q;

  row_ctrl_t              row_ctrl;
  digit_vec_t             digits;

  logic                   start;
  logic [63:0]            num;
  logic [63:0]            mag;
  logic                   neg;
  logic                   slot_free;
  logic                   emit;
  logic [7:0]             body_char;
  logic [7:0]             pre_char;

  assign in_stall_o = (state_q != ST_IDLE);
  assign start      = in_valid_i && (state_q == ST_IDLE) && (func_i <= FuncPtr);
  assign slot_free  = !out_valid_q || !out_stall_i;
  // A character is loaded into the output register in this cycle.
  assign emit       = ((state_q == ST_PRE) || (state_q == ST_BODY)) && slot_free;

  // Operand selection: the low word is sign-extended only for signed decimal.
  always_comb begin
    if (wide_i) begin
      num = value_i;
    end else if (func_i == FuncSDec) begin
      num = {{32{value_i[31]}}, value_i[31:0]};
    end else begin
      num = {32'h0, value_i[31:0]};
    end
    neg = (func_i == FuncSDec) && num[63];
    // Negation wraps, so the most negative value prints its own magnitude.
    mag = neg ? (64'h0 - num) : num;
  end

  assign row_ctrl.clear  = start;
  assign row_ctrl.step   = (state_q == ST_CONV);
  assign row_ctrl.bit_in = shift_q[63];
  assign row_ctrl.base   = base_q;

  itoa_digit_row u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (row_ctrl),
    .digits_o (digits)
  );

  // Positions above the top significant digit are padding.
  assign body_char = (pos_q > {1'b0, idx_q}) ? padc_q
                                             : digit_char(digits[pos_q[DigitIdxW-1:0]]);
  assign pre_char  = ptr_q ? ((pre_left_q == 2'd2) ? CharZero : CharX) : CharMinus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shift_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      width_q     <= '0;
      padc_q      <= CharSpace;
      ptr_q       <= 1'b0;
      pre_left_q  <= '0;
      base_q      <= BASE_10;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            // A 32-bit magnitude always fits the low word, so only 32 steps.
            shift_q    <= wide_i ? mag : {mag[31:0], 32'h0};
            cnt_q      <= wide_i ? 6'd63 : 6'd31;
            ptr_q      <= (func_i == FuncPtr);
            pre_left_q <= (func_i == FuncPtr) ? 2'd2 : (neg ? 2'd1 : 2'd0);
            if (func_i == FuncSDec || func_i == FuncUDec) begin
              base_q <= BASE_10;
            end else if (func_i == FuncOct) begin
              base_q <= BASE_8;
            end else begin
              base_q <= BASE_16;
            end
            if (func_i == FuncPtr) begin
              width_q <= PtrDigitsC;
              padc_q  <= CharZero;
            end else begin
              width_q <= (field_width_i > MaxWidthC) ? MaxWidthC : field_width_i;
              if (pad_mode_i == PadZero) begin
                padc_q <= CharZero;
              end else if (pad_mode_i == PadDash) begin
                padc_q <= CharMinus;
              end else begin
                padc_q <= CharSpace;
              end
            end
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          shift_q <= {shift_q[62:0], 1'b0};
          if (cnt_q == '0) begin
            idx_q   <= DigitIdxW'(NumDigits - 1);
            state_q <= ST_SCAN;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_SCAN: begin
          // Stop at the top nonzero digit; zero keeps its single '0'.
          if (idx_q == '0 || digits[idx_q] != '0) begin
            if (width_q > ({1'b0, idx_q} + 6'd1)) begin
              pos_q <= width_q - 6'd1;
            end else begin
              pos_q <= {1'b0, idx_q};
            end
            state_q <= (pre_left_q != '0) ? ST_PRE : ST_BODY;
          end else begin
            idx_q <= idx_q - DigitIdxW'(1);
          end
        end
        ST_PRE: begin
          if (slot_free) begin
            out_char_q  <= pre_char;
            last_q      <= 1'b0;
            pre_left_q  <= pre_left_q - 2'd1;
            if (pre_left_q == 2'd1) begin
              state_q <= ST_BODY;
            end
          end
        end
        ST_BODY: begin
          if (slot_free) begin
            out_char_q  <= body_char;
            last_q      <= (pos_q == '0);
            if (pos_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q <= pos_q - 6'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for integer_to_ascii_formatter_core.
//
// The sender offers conversion requests in bursts of random length with
// random gaps between them. The receiver follows a stall pattern of its own:
// free-running stretches, random stalls and solid stalls. Early in the run it
// holds off for a long stretch while the directed requests keep coming, so
// the block fills up and has to stall its input.
//
// Every accepted request is expanded by the scoreboard into the exact text
// that it must produce. Each accepted output transaction is then compared
// with the oldest character still waiting.
module tb_top;

  localparam int MAX_W         = 63;
  localparam int PTR_DIGITS    = 16;
  localparam int RANDOM_ITEMS  = 150;
  // Long enough for any work still in flight once the expected text is out.
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 600;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int REPORT_LIMIT  = 40;

  typedef enum logic [2:0] {
    FN_SIGNED_DEC,
    FN_UNSIGNED_DEC,
    FN_OCTAL,
    FN_HEX,
    FN_POINTER,
    FN_UNUSED_5,
    FN_UNUSED_6,
    FN_UNUSED_7
  } conv_e;

  typedef enum logic [1:0] {
    PAD_SPACE,
    PAD_ZERO,
    PAD_DASH,
    PAD_UNUSED
  } pad_e;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // The scoreboard turns each accepted request into its expected characters
  // and checks the output stream against them in order.
  class text_scoreboard;
    text_char_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void note_request(conv_e fn, logic [63:0] value, logic wide,
                               logic [5:0] fw, pad_e pad);
      string      glyphs = "0123456789abcdef";
      logic [63:0] num;
      logic [63:0] radix;
      logic [7:0]  fill;
      logic [7:0]  digits[$];
      logic [7:0]  line[$];
      int          width;
      int          pads;
      text_char_t  entry;

      // Unused conversion codes produce no text at all.
      if (fn > FN_POINTER) return;
      width = (fw > MAX_W) ? MAX_W : int'(fw);
      fill = (pad == PAD_ZERO) ? "0" : (pad == PAD_DASH) ? "-" : " ";

      if (wide) num = value;
      else if (fn == FN_SIGNED_DEC) num = {{32{value[31]}}, value[31:0]};
      else num = {32'd0, value[31:0]};

      case (fn)
        FN_SIGNED_DEC: begin
          radix = 64'd10;
          // The sign goes out ahead of the padding and is not counted in
          // the width. The most negative value wraps back onto itself.
          if (num[63]) begin
            line.push_back("-");
            num = ~num + 64'd1;
          end
        end
        FN_UNSIGNED_DEC: radix = 64'd10;
        FN_OCTAL:        radix = 64'd8;
        FN_HEX:          radix = 64'd16;
        default: begin
          radix = 64'd16;
          line.push_back("0");
          line.push_back("x");
          fill  = "0";
          width = PTR_DIGITS;
        end
      endcase

      do begin
        digits.push_front(glyphs[int'(num % radix)]);
        num = num / radix;
      end while (num != 64'd0);

      pads = width - digits.size();
      for (int i = 0; i < pads; i++) line.push_back(fill);
      foreach (digits[i]) line.push_back(digits[i]);
      while (line.size() > 64) void'(line.pop_back());

      foreach (line[i]) begin
        entry.ch   = line[i];
        entry.last = (i == line.size() - 1);
        pending_chars.push_back(entry);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected character, expected none, actual 0x%02h last %0b",
                   $time, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: out_char mismatch, expected 0x%02h, actual 0x%02h",
                   $time, want.ch, ch);
      end
      if (last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic [63:0] value_i;
  logic        wide_i;
  logic [5:0]  field_width_i;
  logic [1:0]  pad_mode_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_char_o;
  logic        last_o;

  text_scoreboard sb = new();
  int unsigned    cycle_count = 0;

  integer_to_ascii_formatter_core #(
    .MAX_WIDTH     (MAX_W),
    .POINTER_DIGITS(PTR_DIGITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .wide_i       (wide_i),
    .field_width_i(field_width_i),
    .pad_mode_i   (pad_mode_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Output transactions are sampled at the rising edge, before any update
  // made at that edge takes effect.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_char(out_char_o, last_o);
  end

  // A hung block or a lost character ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters still expected", $time, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall pattern. After a short warm-up it holds off for a long
  // stretch, which falls on the directed requests, and then cycles through
  // free-running, random and solid-stall stretches of random length.
  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    for (int i = 0; i < 150; i++) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      @(posedge clk_i);
    end
    out_stall_i <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= 1'b1;
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. The caller
  // must be at a rising edge. Valid is left high so that a burst can go on.
  task automatic send_request(conv_e fn, logic [63:0] value, logic wide,
                              logic [5:0] fw, pad_e pad);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    value_i       <= value;
    wide_i        <= wide;
    field_width_i <= fw;
    pad_mode_i    <= pad;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(fn, value, wide, fw, pad);
  endtask

  // Waits until every expected character has come out, then lets the block
  // finish anything that produces no text.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 1000));
      3: v = -64'($urandom_range(1, 100000));
      4: begin
        case ($urandom_range(0, 5))
          0:       v = 64'd0;
          1:       v = '1;
          2:       v = 64'h8000_0000_0000_0000;
          3:       v = 64'h7fff_ffff_ffff_ffff;
          4:       v = {$urandom, 32'h8000_0000};
          default: v = {$urandom, 32'h7fff_ffff};
        endcase
      end
      default: v = {$urandom, $urandom} >> ($urandom_range(0, 1) * 32);
    endcase
    return v;
  endfunction

  initial begin
    conv_e       fn;
    logic [63:0] value;
    logic [5:0]  fw;
    int          taken;
    int          burst;
    int          gap;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = '0;
    value_i       = '0;
    wide_i        = 1'b0;
    field_width_i = '0;
    pad_mode_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests, offered back to back.
    send_request(FN_SIGNED_DEC, 64'd0, 1'b1, 6'd0, PAD_SPACE);
    send_request(FN_SIGNED_DEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, PAD_SPACE);
    send_request(FN_SIGNED_DEC, 64'h0000_0000_ffff_ffff, 1'b0, 6'd5, PAD_ZERO);
    send_request(FN_SIGNED_DEC, 64'h1234_5678_8000_0000, 1'b0, 6'd0, PAD_SPACE);
    send_request(FN_SIGNED_DEC, 64'h7fff_ffff_ffff_ffff, 1'b1, 6'd63, PAD_DASH);
    send_request(FN_SIGNED_DEC, -64'd42, 1'b1, 6'd10, PAD_DASH);
    send_request(FN_SIGNED_DEC, 64'hffff_ffff_0000_007b, 1'b0, 6'd2, PAD_UNUSED);
    send_request(FN_UNSIGNED_DEC, '1, 1'b1, 6'd0, PAD_SPACE);
    send_request(FN_UNSIGNED_DEC, '1, 1'b0, 6'd12, PAD_SPACE);
    send_request(FN_UNSIGNED_DEC, 64'd0, 1'b1, 6'd63, PAD_SPACE);
    send_request(FN_UNSIGNED_DEC, 64'd10000000000000000000, 1'b1, 6'd20, PAD_ZERO);
    send_request(FN_OCTAL, '1, 1'b1, 6'd63, PAD_ZERO);
    send_request(FN_OCTAL, 64'd0, 1'b1, 6'd63, PAD_UNUSED);
    send_request(FN_OCTAL, 64'h8000_0000_ffff_ffff, 1'b0, 6'd1, PAD_DASH);
    send_request(FN_HEX, 64'hdead_beef_cafe_f00d, 1'b1, 6'd20, PAD_DASH);
    send_request(FN_HEX, 64'hffff_ffff_0000_00ab, 1'b0, 6'd0, PAD_SPACE);
    send_request(FN_HEX, '1, 1'b1, 6'd63, PAD_SPACE);
    send_request(FN_POINTER, 64'd0, 1'b1, 6'd0, PAD_SPACE);
    send_request(FN_POINTER, '1, 1'b0, 6'd5, PAD_SPACE);
    send_request(FN_POINTER, '1, 1'b1, 6'd63, PAD_DASH);
    send_request(FN_UNUSED_5, '1, 1'b1, 6'd63, PAD_ZERO);
    send_request(FN_UNUSED_6, 64'd77, 1'b0, 6'd3, PAD_DASH);
    send_request(FN_UNUSED_7, 64'h8000_0000_0000_0000, 1'b1, 6'd0, PAD_UNUSED);
    send_request(FN_SIGNED_DEC, 64'd5, 1'b0, 6'd63, PAD_ZERO);

    // Let everything come out before the random part starts.
    in_valid_i <= 1'b0;
    wait_drained();

    // Random requests in bursts. Unused conversion codes are mixed in but do
    // not count, since the block only swallows them.
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && taken < RANDOM_ITEMS; k++) begin
        fn    = ($urandom_range(0, 19) == 0) ? conv_e'($urandom_range(5, 7))
                                             : conv_e'($urandom_range(0, 4));
        value = random_operand();
        fw    = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 24));
        send_request(fn, value, 1'($urandom_range(0, 1)), fw,
                     pad_e'($urandom_range(0, 3)));
        if (fn <= FN_POINTER) taken++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/core/itoa_pkg.sv
rtl/core/itoa_digit_row.sv
rtl/core/integer_to_ascii_formatter_core.sv
test/tb_top.sv
